@@ sv/tsre_pkg.sv @@
`timescale 1ns / 1ps

package tsre_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 10;
  localparam int Q_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_SA   = 4'd0,
    OP_SB   = 4'd1,
    OP_SS   = 4'd2,
    OP_PA   = 4'd3,
    OP_PB   = 4'd4,
    OP_RA   = 4'd5,
    OP_RB   = 4'd6,
    OP_RR   = 4'd7,
    OP_RRA  = 4'd8,
    OP_RRB  = 4'd9,
    OP_RRR  = 4'd10,
    OP_LOAD = 4'd11
  } opcode_t;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_UNKNOWN = 2'd1,
    STS_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LOP_NOP,
    LOP_SWAP,
    LOP_ROT,
    LOP_RROT
  } lane_op_t;

  typedef enum logic [1:0] {
    CK_STACK,
    CK_PUSH,
    CK_LOAD,
    CK_REJECT
  } cmd_kind_t;

  // lane 0 is stack A, lane 1 is stack B
  typedef struct packed {
    cmd_kind_t               kind;
    lane_op_t [1:0]          lane_op;
    logic                    push_src;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

endpackage

@@ sv/tsre_ram.sv @@
`timescale 1ns / 1ps

module tsre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/tsre_front.sv @@
`timescale 1ns / 1ps

module tsre_front (
  input  logic                              start,
  output logic                              busy,
  input  logic [3:0]                        in_operation,
  input  logic signed [tsre_pkg::WORD_W-1:0] in_load_value,
  input  logic                              q_full,
  output logic                              push,
  output tsre_pkg::cmd_t                    cmd
);

  assign busy = q_full;
  assign push = start & ~q_full;

  always_comb begin
    cmd.kind       = tsre_pkg::CK_STACK;
    cmd.lane_op[0] = tsre_pkg::LOP_NOP;
    cmd.lane_op[1] = tsre_pkg::LOP_NOP;
    cmd.push_src   = 1'b0;
    cmd.value      = in_load_value;
    case (in_operation)
      tsre_pkg::OP_SA:  cmd.lane_op[0] = tsre_pkg::LOP_SWAP;
      tsre_pkg::OP_SB:  cmd.lane_op[1] = tsre_pkg::LOP_SWAP;
      tsre_pkg::OP_SS: begin
        cmd.lane_op[0] = tsre_pkg::LOP_SWAP;
        cmd.lane_op[1] = tsre_pkg::LOP_SWAP;
      end
      tsre_pkg::OP_PA: begin
        cmd.kind     = tsre_pkg::CK_PUSH;
        cmd.push_src = 1'b1;
      end
      tsre_pkg::OP_PB: begin
        cmd.kind     = tsre_pkg::CK_PUSH;
        cmd.push_src = 1'b0;
      end
      tsre_pkg::OP_RA:  cmd.lane_op[0] = tsre_pkg::LOP_ROT;
      tsre_pkg::OP_RB:  cmd.lane_op[1] = tsre_pkg::LOP_ROT;
      tsre_pkg::OP_RR: begin
        cmd.lane_op[0] = tsre_pkg::LOP_ROT;
        cmd.lane_op[1] = tsre_pkg::LOP_ROT;
      end
      tsre_pkg::OP_RRA: cmd.lane_op[0] = tsre_pkg::LOP_RROT;
      tsre_pkg::OP_RRB: cmd.lane_op[1] = tsre_pkg::LOP_RROT;
      tsre_pkg::OP_RRR: begin
        cmd.lane_op[0] = tsre_pkg::LOP_RROT;
        cmd.lane_op[1] = tsre_pkg::LOP_RROT;
      end
      tsre_pkg::OP_LOAD: cmd.kind = tsre_pkg::CK_LOAD;
      default:           cmd.kind = tsre_pkg::CK_REJECT;
    endcase
  end

endmodule

@@ sv/tsre_queue.sv @@
`timescale 1ns / 1ps

module tsre_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tsre_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output tsre_pkg::cmd_t head
);

  localparam int PW = $clog2(tsre_pkg::Q_DEPTH);
  localparam int CW = $clog2(tsre_pkg::Q_DEPTH + 1);

  tsre_pkg::cmd_t slot_r [tsre_pkg::Q_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(tsre_pkg::Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(tsre_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(tsre_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/tsre_back.sv @@
`timescale 1ns / 1ps

module tsre_back #(
  parameter int CAPACITY = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  tsre_pkg::cmd_t                      q_head,
  output logic                                pop,
  output logic                                out_strobe,
  output logic [1:0]                          out_status,
  output logic [tsre_pkg::COUNT_W-1:0]        out_count_a,
  output logic [tsre_pkg::COUNT_W-1:0]        out_count_b,
  output logic signed [tsre_pkg::WORD_W-1:0]  out_top_a,
  output logic signed [tsre_pkg::WORD_W-1:0]  out_top_b
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int SW = FW + 1;
  localparam int WW = tsre_pkg::WORD_W;
  localparam int CW = tsre_pkg::COUNT_W;

  typedef enum logic {S_IDLE, S_FIN} state_t;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [FW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [IW-1:0]        top_r  [2];
  logic [IW-1:0]        top_nxt[2];
  logic [FW-1:0]        fill_r [2];
  logic [FW-1:0]        fill_nxt[2];
  logic signed [WW-1:0] tv_r   [2];
  logic signed [WW-1:0] tv_nxt [2];
  logic                 cap_r  [2];
  logic                 cap_nxt[2];
  logic                 fwr_r  [2];
  logic                 fwr_nxt[2];
  logic [1:0]           status_r, status_nxt;

  logic                 strobe_nxt;
  logic [1:0]           ostat_nxt;
  logic [CW-1:0]        ocnt_a_nxt, ocnt_b_nxt;
  logic signed [WW-1:0] otop_a_nxt, otop_b_nxt;

  logic [IW-1:0]        nxt1[2];
  logic [IW-1:0]        prv [2];
  logic [IW-1:0]        bot [2];
  logic [IW-1:0]        last[2];

  logic                 we   [2];
  logic [IW-1:0]        waddr[2];
  logic signed [WW-1:0] wdata[2];
  logic [IW-1:0]        raddr[2];
  logic signed [WW-1:0] rdata[2];

  logic                 src, dst;
  logic signed [WW-1:0] top_val[2];

  tsre_ram #(.WIDTH(WW), .DEPTH(CAPACITY)) u_ring_a (
    .clk   (clk),
    .we    (we[0]),
    .waddr (waddr[0]),
    .wdata (wdata[0]),
    .raddr (raddr[0]),
    .rdata (rdata[0])
  );

  tsre_ram #(.WIDTH(WW), .DEPTH(CAPACITY)) u_ring_b (
    .clk   (clk),
    .we    (we[1]),
    .waddr (waddr[1]),
    .wdata (wdata[1]),
    .raddr (raddr[1]),
    .rdata (rdata[1])
  );

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      nxt1[s] = wrap_add(top_r[s], FW'(1));
      prv[s]  = (top_r[s] == '0) ? IW'(CAPACITY - 1) : top_r[s] - IW'(1);
      bot[s]  = wrap_add(top_r[s], fill_r[s]);
      last[s] = wrap_add(top_r[s], fill_r[s] - FW'(1));
    end
  end

  always_comb begin
    src        = q_head.push_src;
    dst        = ~q_head.push_src;
    pop        = 1'b0;
    state_nxt  = state_r;
    status_nxt = status_r;
    strobe_nxt = 1'b0;
    ostat_nxt  = out_status;
    ocnt_a_nxt = out_count_a;
    ocnt_b_nxt = out_count_b;
    otop_a_nxt = out_top_a;
    otop_b_nxt = out_top_b;
    for (int s = 0; s < 2; s++) begin
      top_nxt[s]  = top_r[s];
      fill_nxt[s] = fill_r[s];
      tv_nxt[s]   = tv_r[s];
      cap_nxt[s]  = cap_r[s];
      fwr_nxt[s]  = fwr_r[s];
      we[s]       = 1'b0;
      waddr[s]    = top_r[s];
      wdata[s]    = tv_r[s];
      raddr[s]    = nxt1[s];
      top_val[s]  = '0;
    end
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_nxt  = S_FIN;
          status_nxt = tsre_pkg::STS_DONE;
          for (int s = 0; s < 2; s++) begin
            cap_nxt[s] = 1'b0;
            fwr_nxt[s] = 1'b0;
          end
          case (q_head.kind)
            tsre_pkg::CK_STACK: begin
              for (int s = 0; s < 2; s++) begin
                if (fill_r[s] >= FW'(2)) begin
                  case (q_head.lane_op[s])
                    tsre_pkg::LOP_SWAP: begin
                      we[s]      = 1'b1;
                      waddr[s]   = nxt1[s];
                      raddr[s]   = nxt1[s];
                      cap_nxt[s] = 1'b1;
                      fwr_nxt[s] = 1'b1;
                    end
                    tsre_pkg::LOP_ROT: begin
                      we[s]      = 1'b1;
                      waddr[s]   = bot[s];
                      raddr[s]   = nxt1[s];
                      top_nxt[s] = nxt1[s];
                      cap_nxt[s] = 1'b1;
                    end
                    tsre_pkg::LOP_RROT: begin
                      raddr[s]   = last[s];
                      top_nxt[s] = prv[s];
                      cap_nxt[s] = 1'b1;
                      fwr_nxt[s] = 1'b1;
                    end
                    default: ;
                  endcase
                end
              end
            end
            tsre_pkg::CK_PUSH: begin
              if (fill_r[src] != '0 && fill_r[dst] < FW'(CAPACITY)) begin
                raddr[src]    = nxt1[src];
                top_nxt[src]  = nxt1[src];
                fill_nxt[src] = fill_r[src] - FW'(1);
                cap_nxt[src]  = 1'b1;
                we[dst]       = 1'b1;
                waddr[dst]    = prv[dst];
                wdata[dst]    = tv_r[src];
                top_nxt[dst]  = prv[dst];
                fill_nxt[dst] = fill_r[dst] + FW'(1);
                tv_nxt[dst]   = tv_r[src];
              end
            end
            tsre_pkg::CK_LOAD: begin
              if ((SW'(fill_r[0]) + SW'(fill_r[1])) < SW'(CAPACITY)) begin
                we[0]       = 1'b1;
                waddr[0]    = bot[0];
                wdata[0]    = q_head.value;
                fill_nxt[0] = fill_r[0] + FW'(1);
                if (fill_r[0] == '0) begin
                  tv_nxt[0] = q_head.value;
                end
              end else begin
                status_nxt = tsre_pkg::STS_FULL;
              end
            end
            default: status_nxt = tsre_pkg::STS_UNKNOWN;
          endcase
        end
      end
      S_FIN: begin
        for (int s = 0; s < 2; s++) begin
          if (fwr_r[s]) begin
            we[s]    = 1'b1;
            waddr[s] = top_r[s];
            wdata[s] = rdata[s];
          end
          if (cap_r[s]) begin
            tv_nxt[s] = rdata[s];
          end
          top_val[s] = (fill_r[s] == '0) ? '0 : tv_nxt[s];
        end
        strobe_nxt = 1'b1;
        ostat_nxt  = status_r;
        ocnt_a_nxt = CW'(fill_r[0]);
        ocnt_b_nxt = CW'(fill_r[1]);
        otop_a_nxt = top_val[0];
        otop_b_nxt = top_val[1];
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_strobe <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        top_r[s]  <= '0;
        fill_r[s] <= '0;
        cap_r[s]  <= 1'b0;
        fwr_r[s]  <= 1'b0;
      end
    end else begin
      state_r    <= state_nxt;
      out_strobe <= strobe_nxt;
      for (int s = 0; s < 2; s++) begin
        top_r[s]  <= top_nxt[s];
        fill_r[s] <= fill_nxt[s];
        cap_r[s]  <= cap_nxt[s];
        fwr_r[s]  <= fwr_nxt[s];
      end
    end
    for (int s = 0; s < 2; s++) begin
      tv_r[s] <= tv_nxt[s];
    end
    status_r    <= status_nxt;
    out_status  <= ostat_nxt;
    out_count_a <= ocnt_a_nxt;
    out_count_b <= ocnt_b_nxt;
    out_top_a   <= otop_a_nxt;
    out_top_b   <= otop_b_nxt;
  end

endmodule

@@ sv/two_stack_rotate_engine.sv @@
`timescale 1ns / 1ps

// Two stacks of signed 32-bit words, A and B, each a ring of CAPACITY entries.
// An operation is taken when start is high and busy is low; busy rises only
// while the two-entry command queue is full. The execution unit issues the ring
// read/write in S_IDLE and captures the read word and writes back in S_FIN; it
// takes no new operation until it is back in S_IDLE, as each ring has a single
// write port. Each operation gives exactly one result word, shown for one cycle
// with out_strobe high after it has passed the queue, S_IDLE, S_FIN and the
// output registers. The receiver cannot stall: it must take the word in the
// cycle out_strobe is high. No clearing pass after reset.
module two_stack_rotate_engine #(
  parameter int CAPACITY = 512
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [3:0]                         in_operation,
  input  logic signed [tsre_pkg::WORD_W-1:0] in_load_value,
  output logic                               out_strobe,
  output logic [1:0]                         out_status,
  output logic [tsre_pkg::COUNT_W-1:0]       out_count_a,
  output logic [tsre_pkg::COUNT_W-1:0]       out_count_b,
  output logic signed [tsre_pkg::WORD_W-1:0] out_top_a,
  output logic signed [tsre_pkg::WORD_W-1:0] out_top_b
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  tsre_pkg::cmd_t f_cmd;
  tsre_pkg::cmd_t q_head;

  tsre_front u_front (
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_load_value (in_load_value),
    .q_full        (q_full),
    .push          (q_push),
    .cmd           (f_cmd)
  );

  tsre_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (f_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  tsre_back #(.CAPACITY(CAPACITY)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .pop         (q_pop),
    .out_strobe  (out_strobe),
    .out_status  (out_status),
    .out_count_a (out_count_a),
    .out_count_b (out_count_b),
    .out_top_a   (out_top_a),
    .out_top_b   (out_top_b)
  );

endmodule

@@ sv/tsre_checker.sv @@
`timescale 1ns / 1ps

module tsre_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_strobe,
  input logic [1:0]                         out_status,
  input logic [tsre_pkg::COUNT_W-1:0]       out_count_a,
  input logic [tsre_pkg::COUNT_W-1:0]       out_count_b,
  input logic signed [tsre_pkg::WORD_W-1:0] out_top_a,
  input logic signed [tsre_pkg::WORD_W-1:0] out_top_b
);

  // execution returns to S_IDLE after each result: result words never come back to back
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result words on consecutive cycles");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == tsre_pkg::STS_DONE ||
                    out_status == tsre_pkg::STS_UNKNOWN ||
                    out_status == tsre_pkg::STS_FULL))
    else $error("undefined status code");

  a_empty_top_a: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_count_a == '0) |-> (out_top_a == '0))
    else $error("empty stack A shows nonzero top");

  a_empty_top_b: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_count_b == '0) |-> (out_top_b == '0))
    else $error("empty stack B shows nonzero top");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result word right after reset");

endmodule

bind two_stack_rotate_engine tsre_checker u_tsre_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_strobe  (out_strobe),
  .out_status  (out_status),
  .out_count_a (out_count_a),
  .out_count_b (out_count_b),
  .out_top_a   (out_top_a),
  .out_top_b   (out_top_b)
);
